### sv/frpr_pkg.sv
// shared types and constants for the framed packet receiver
// no dependencies; used by every module of the block but frpr_buf
package frpr_pkg;

  // input item kinds carried on tuser
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // result status codes
  localparam logic [1:0] ST_GOOD = 2'd0;
  localparam logic [1:0] ST_CSUM = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;

  // one finished frame, handed from the parser to the result generator
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [7:0]  func;
    logic [15:0] len;
    logic [31:0] frames;
    logic [31:0] errs;
    logic [31:0] overlong;
  } desc_t;

endpackage

### sv/framed_packet_receiver_dual_checksum.sv
// top level of the framed packet receiver with sum and add-of-sums check
// depends on frpr_pkg, frpr_front, frpr_queue, frpr_buf, frpr_back
//
// Byte-stream frame receiver. Each slave-side transaction carries one received byte
// (tuser = 0) or a restart command (tuser = 1). The parser hunts for the head byte
// (cfg_data, 0xAB after reset), then takes source, destination, function, a
// little-endian 16-bit length, the payload, a sum byte and an add byte. At the add
// byte it produces a good run (one transaction per payload byte, tlast on the final
// one, a single empty-data transaction for a zero-length frame), or one checksum-error
// or one over-length transaction. Every result carries the three frame counters as
// they stand after that frame. Rate: the parser takes one byte per cycle while
// s_axis_tready is high. The result generator gives each payload byte a registered
// read of the payload store before it is shown, and starts the next read only once
// the shown transaction is taken. A two-entry descriptor queue lets the parser run
// ahead (s_axis_tready is low while it is full), and payload bytes of a new frame
// are held off (s_axis_tready low) until the previous run has fully left the store.
// Write cfg_data only while the block is idle.
module framed_packet_receiver_dual_checksum #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic         clk,
  input  logic         rst,
  // configuration write channel, head byte
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data,
  // input transactions
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  input  logic         s_axis_tuser,   // [0] cmd
  // result transactions
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] source_addr, [15:8] dest_addr, [23:16] function_id, [39:24] payload_len,
  // [47:40] data_byte, [53:48] byte_index, [85:54] frames_seen,
  // [117:86] checksum_errors, [149:118] overlong_frames, [151:150] zero
  output logic [151:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // [1:0] status
  output logic         m_axis_tlast    // last
);
  import frpr_pkg::*;

  // store address and run index widths, kept at least one bit
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD + 1) : 1;

  desc_t          push_data;
  desc_t          pop_data;
  logic           push;
  logic           pop;
  logic           q_empty;
  logic           q_full;
  logic           back_active;
  logic           back_busy;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic [7:0]     mem_rdata;

  logic [1:0]     r_status;
  logic [7:0]     r_src;
  logic [7:0]     r_dst;
  logic [7:0]     r_func;
  logic [15:0]    r_len;
  logic [7:0]     r_data;
  logic [5:0]     r_index;
  logic [31:0]    r_frames;
  logic [31:0]    r_errs;
  logic [31:0]    r_overlong;

  // the head byte register accepts a write at any time
  assign cfg_ready = 1'b1;

  // store is in use while any descriptor waits or a run is being emitted
  assign back_busy = !q_empty || back_active;

  frpr_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_cmd    (s_axis_tuser),
    .in_byte   (s_axis_tdata),
    .in_ready  (s_axis_tready),
    .back_busy (back_busy),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data),
    .mem_we    (mem_we),
    .mem_addr  (mem_waddr),
    .mem_data  (mem_wdata)
  );

  frpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  frpr_buf #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_buf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  frpr_back #(
    .AW          (AW),
    .CW          (CW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (pop_data),
    .q_pop        (pop),
    .active       (back_active),
    .rd_en        (mem_re),
    .rd_addr      (mem_raddr),
    .rd_data      (mem_rdata),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_status   (r_status),
    .out_src      (r_src),
    .out_dst      (r_dst),
    .out_func     (r_func),
    .out_len      (r_len),
    .out_data     (r_data),
    .out_index    (r_index),
    .out_last     (m_axis_tlast),
    .out_frames   (r_frames),
    .out_errs     (r_errs),
    .out_overlong (r_overlong)
  );

  // pack the result fields, first field lowest
  assign m_axis_tuser = r_status;
  assign m_axis_tdata = {2'b00, r_overlong, r_errs, r_frames, r_index, r_data,
                         r_len, r_func, r_dst, r_src};

endmodule

### sv/frpr_buf.sv
// payload store: one write port, one registered read port
// depends on nothing but its parameters
module frpr_buf #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/frpr_queue.sv
// two-entry queue of finished frame descriptors
// depends on frpr_pkg
module frpr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  frpr_pkg::desc_t push_data,
  input  logic          pop,
  output frpr_pkg::desc_t pop_data,
  output logic          empty,
  output logic          full
);
  import frpr_pkg::*;

  desc_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty    = (count == 2'd0);
  assign full     = (count == 2'd2);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/frpr_front.sv
// front end: head hunt, header parse, running checks, payload store writes
// depends on frpr_pkg; hands finished frames to the descriptor queue
module frpr_front #(
  parameter int MAX_PAYLOAD = 64,
  parameter int AW          = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic [7:0]      cfg_data,
  input  logic            in_valid,
  input  logic            in_cmd,
  input  logic [7:0]      in_byte,
  output logic            in_ready,
  input  logic            back_busy,
  input  logic            q_full,
  output logic            push,
  output frpr_pkg::desc_t push_data,
  output logic            mem_we,
  output logic [AW-1:0]   mem_addr,
  output logic [7:0]      mem_data
);
  import frpr_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT, PH_SRC, PH_DST, PH_FUNC, PH_LEN1, PH_LEN2, PH_DATA, PH_SUM, PH_ADD
  } phase_t;

  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  phase_t      phase;
  logic [7:0]  head_byte;
  logic [7:0]  src;
  logic [7:0]  dst;
  logic [7:0]  func;
  logic [15:0] len;
  logic [15:0] count;
  logic [7:0]  run_sum;
  logic [7:0]  run_add;
  logic [7:0]  got_sum;
  logic [31:0] frames;
  logic [31:0] errs;
  logic [31:0] overlong;

  logic        take;
  logic [7:0]  sum_next;
  logic [7:0]  add_next;
  logic [15:0] count_next;
  logic        too_long;
  logic        csum_ok;
  logic [31:0] frames_next;
  logic [31:0] errs_next;
  logic [31:0] overlong_next;

  // payload writes wait until the previous run has left the store
  assign in_ready = !q_full && !((phase == PH_DATA) && back_busy);
  assign take     = in_valid && in_ready;

  assign sum_next   = run_sum + in_byte;
  assign add_next   = run_add + sum_next;
  assign count_next = count + 16'd1;
  assign too_long   = (len > MaxLen);
  assign csum_ok    = (run_sum == got_sum) && (run_add == in_byte);

  assign frames_next   = frames + 32'd1;
  assign overlong_next = too_long ? overlong + 32'd1 : overlong;
  assign errs_next     = (!too_long && !csum_ok) ? errs + 32'd1 : errs;

  assign push = take && (in_cmd == CMD_BYTE) && (phase == PH_ADD);

  always_comb begin
    push_data.src      = src;
    push_data.dst      = dst;
    push_data.func     = func;
    push_data.len      = len;
    push_data.frames   = frames_next;
    push_data.errs     = errs_next;
    push_data.overlong = overlong_next;
    if (too_long) begin
      push_data.status = ST_LONG;
    end else if (csum_ok) begin
      push_data.status = ST_GOOD;
    end else begin
      push_data.status = ST_CSUM;
    end
  end

  assign mem_we   = take && (in_cmd == CMD_BYTE) && (phase == PH_DATA) && (count < MaxLen);
  assign mem_addr = count[AW-1:0];
  assign mem_data = in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte <= 8'hAB;
    end else if (cfg_valid) begin
      head_byte <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HUNT;
      src      <= 8'd0;
      dst      <= 8'd0;
      func     <= 8'd0;
      len      <= 16'd0;
      count    <= 16'd0;
      run_sum  <= 8'd0;
      run_add  <= 8'd0;
      got_sum  <= 8'd0;
      frames   <= 32'd0;
      errs     <= 32'd0;
      overlong <= 32'd0;
    end else if (take) begin
      if (in_cmd == CMD_RESTART) begin
        phase   <= PH_HUNT;
        count   <= 16'd0;
        run_sum <= 8'd0;
        run_add <= 8'd0;
      end else begin
        unique case (phase)
          PH_HUNT: begin
            if (in_byte == head_byte) begin
              run_sum <= in_byte;
              run_add <= in_byte;
              count   <= 16'd0;
              phase   <= PH_SRC;
            end
          end
          PH_SRC: begin
            src     <= in_byte;
            run_sum <= sum_next;
            run_add <= add_next;
            phase   <= PH_DST;
          end
          PH_DST: begin
            dst     <= in_byte;
            run_sum <= sum_next;
            run_add <= add_next;
            phase   <= PH_FUNC;
          end
          PH_FUNC: begin
            func    <= in_byte;
            run_sum <= sum_next;
            run_add <= add_next;
            phase   <= PH_LEN1;
          end
          PH_LEN1: begin
            len     <= {8'd0, in_byte};
            run_sum <= sum_next;
            run_add <= add_next;
            phase   <= PH_LEN2;
          end
          PH_LEN2: begin
            len     <= {in_byte, len[7:0]};
            run_sum <= sum_next;
            run_add <= add_next;
            // empty payload skips straight to the check bytes
            phase   <= ({in_byte, len[7:0]} == 16'd0) ? PH_SUM : PH_DATA;
          end
          PH_DATA: begin
            run_sum <= sum_next;
            run_add <= add_next;
            count   <= count_next;
            if (count_next == len) begin
              phase <= PH_SUM;
            end
          end
          PH_SUM: begin
            got_sum <= in_byte;
            phase   <= PH_ADD;
          end
          PH_ADD: begin
            frames   <= frames_next;
            errs     <= errs_next;
            overlong <= overlong_next;
            phase    <= PH_HUNT;
            count    <= 16'd0;
            run_sum  <= 8'd0;
            run_add  <= 8'd0;
          end
          default: begin
            phase   <= PH_HUNT;
            count   <= 16'd0;
            run_sum <= 8'd0;
            run_add <= 8'd0;
          end
        endcase
      end
    end
  end

endmodule

### sv/frpr_back.sv
// back end: turns frame descriptors into result transactions
// depends on frpr_pkg; reads the payload store one byte at a time
module frpr_back #(
  parameter int AW          = 6,
  parameter int CW          = 7
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  frpr_pkg::desc_t q_data,
  output logic            q_pop,
  output logic            active,
  output logic            rd_en,
  output logic [AW-1:0]   rd_addr,
  input  logic [7:0]      rd_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_status,
  output logic [7:0]      out_src,
  output logic [7:0]      out_dst,
  output logic [7:0]      out_func,
  output logic [15:0]     out_len,
  output logic [7:0]      out_data,
  output logic [5:0]      out_index,
  output logic            out_last,
  output logic [31:0]     out_frames,
  output logic [31:0]     out_errs,
  output logic [31:0]     out_overlong
);
  import frpr_pkg::*;

  typedef enum logic [1:0] {
    BK_IDLE, BK_READ, BK_SHOW
  } bstate_t;

  bstate_t       state;
  desc_t         cur;
  logic          use_mem;
  logic [CW-1:0] idx;
  logic [15:0]   idx16;
  logic          run_end;

  assign q_pop   = (state == BK_IDLE) && !q_empty;
  assign active  = (state != BK_IDLE);
  assign rd_en   = (state == BK_READ);
  assign rd_addr = idx[AW-1:0];
  assign idx16   = 16'(idx);
  assign run_end = !use_mem || ((idx16 + 16'd1) == cur.len);

  assign out_valid    = (state == BK_SHOW);
  assign out_status   = cur.status;
  assign out_src      = cur.src;
  assign out_dst      = cur.dst;
  assign out_func     = cur.func;
  assign out_len      = cur.len;
  assign out_data     = use_mem ? rd_data : 8'd0;
  assign out_index    = idx16[5:0];
  assign out_last     = run_end;
  assign out_frames   = cur.frames;
  assign out_errs     = cur.errs;
  assign out_overlong = cur.overlong;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      use_mem <= 1'b0;
      idx     <= '0;
    end else begin
      unique case (state)
        BK_IDLE: begin
          if (!q_empty) begin
            cur <= q_data;
            idx <= '0;
            if ((q_data.status == ST_GOOD) && (q_data.len != 16'd0)) begin
              use_mem <= 1'b1;
              state   <= BK_READ;
            end else begin
              use_mem <= 1'b0;
              state   <= BK_SHOW;
            end
          end
        end
        BK_READ: begin
          state <= BK_SHOW;
        end
        BK_SHOW: begin
          if (out_ready) begin
            if (run_end) begin
              state <= BK_IDLE;
            end else begin
              idx   <= idx + CW'(1);
              state <= BK_READ;
            end
          end
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
    end
  end

endmodule
